### hdl/erm_pkg.sv
// erm_pkg: shared constants, types and tables for the euler rotation matrix unit
// used by euler_rotation_matrix_unit; depends on nothing
`default_nettype none
package erm_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int FRAC_BITS    = 14;
  localparam int ENTRY_W      = 16;
  localparam int CORDIC_STEPS = 28;
  localparam int XY_W         = 44;
  localparam int Z_W          = 33;
  localparam int SAT_W        = 20;
  localparam int PROD_W       = 32;

  // gain-compensated start value of the cordic, Q40
  localparam logic signed [XY_W-1:0] GAIN_Q40 = XY_W'(64'sd667681663043);
  localparam logic signed [ENTRY_W-1:0] ONE = ENTRY_W'(1 << FRAC_BITS);

  typedef enum logic [1:0] {
    ACT_ROT_X     = 2'd0,
    ACT_ROT_Y     = 2'd1,
    ACT_ROT_Z     = 2'd2,
    ACT_COMPOSITE = 2'd3
  } action_e;

  typedef logic signed [ENTRY_W-1:0] entry_t;

  // arctangent of 2^-i in 2^32-per-turn units
  function automatic logic signed [Z_W-1:0] atan_turn(input int idx);
    logic signed [Z_W-1:0] r;
    unique case (idx)
      0:  r = Z_W'(536870912);
      1:  r = Z_W'(316933406);
      2:  r = Z_W'(167458907);
      3:  r = Z_W'(85004756);
      4:  r = Z_W'(42667331);
      5:  r = Z_W'(21354465);
      6:  r = Z_W'(10679838);
      7:  r = Z_W'(5340245);
      8:  r = Z_W'(2670163);
      9:  r = Z_W'(1335087);
      10: r = Z_W'(667544);
      11: r = Z_W'(333772);
      12: r = Z_W'(166886);
      13: r = Z_W'(83443);
      14: r = Z_W'(41721);
      15: r = Z_W'(20860);
      16: r = Z_W'(10430);
      17: r = Z_W'(5215);
      18: r = Z_W'(2607);
      19: r = Z_W'(1303);
      20: r = Z_W'(651);
      21: r = Z_W'(325);
      22: r = Z_W'(162);
      23: r = Z_W'(81);
      24: r = Z_W'(40);
      25: r = Z_W'(20);
      26: r = Z_W'(10);
      27: r = Z_W'(5);
      default: r = '0;
    endcase
    return r;
  endfunction

  // clamp a rounded value to [-1.0, 1.0]
  function automatic entry_t sat_one(input logic signed [SAT_W-1:0] v);
    entry_t r;
    if (v > SAT_W'(1 << FRAC_BITS)) r = ONE;
    else if (v < -SAT_W'(1 << FRAC_BITS)) r = -ONE;
    else r = v[ENTRY_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/euler_rotation_matrix_unit.sv
// euler_rotation_matrix_unit: pipelined cordic sine/cosine and 3x3 matrix product
// depends on erm_pkg
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries an action code and three
//   16-bit binary angles. Output channel (out_valid_o / out_ready_i) carries
//   the nine Q1.14 entries of the rotation matrix, row-major, one result per
//   input transfer, in order.
//   Pipeline: 29 cordic register stages for the three angles in parallel,
//   one round stage, then two product/sum pairs for the composite
//   Rx*Ry*Rz; the last sum register drives the outputs.
//   Throughput: one item per cycle while the skid register is empty; each
//   cordic iteration and each multiply has its own register stage.
//   Stall: a two-entry output (register plus skid register) lets the block
//   take one more transfer after the receiver stops; the whole pipeline then
//   holds while the skid register is full and in_ready_o is low.
//   Reset: rst_ni clears all valid bits; no result is produced until the
//   first input transfer.
`default_nettype none
module euler_rotation_matrix_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [1:0]  action_i,
  input  wire  [15:0] angle_x_i,
  input  wire  [15:0] angle_y_i,
  input  wire  [15:0] angle_z_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic signed [15:0] row0_col0_o,
  output logic signed [15:0] row0_col1_o,
  output logic signed [15:0] row0_col2_o,
  output logic signed [15:0] row1_col0_o,
  output logic signed [15:0] row1_col1_o,
  output logic signed [15:0] row1_col2_o,
  output logic signed [15:0] row2_col0_o,
  output logic signed [15:0] row2_col1_o,
  output logic signed [15:0] row2_col2_o
);

  localparam int NS   = erm_pkg::CORDIC_STEPS;
  localparam int AB   = erm_pkg::ANGLE_BITS;
  localparam int XW   = erm_pkg::XY_W;
  localparam int ZW   = erm_pkg::Z_W;
  localparam int FB   = erm_pkg::FRAC_BITS;
  localparam int SW   = erm_pkg::SAT_W;
  localparam int PW   = erm_pkg::PROD_W;
  localparam int RSH  = 40 - FB;

  // global advance: pipeline moves unless the skid register is full
  logic en;
  logic skid_v_q;
  assign en = !skid_v_q;
  assign in_ready_o = en;

  // valid bits
  logic [NS:0] cv_q;
  logic rv_q, p1v_q, a1v_q, p2v_q, fv_q;

  // cordic stage registers
  logic signed [XW-1:0] cx_q [0:NS][0:2];
  logic signed [XW-1:0] cy_q [0:NS][0:2];
  logic signed [ZW-1:0] cz_q [0:NS][0:2];
  logic [1:0]           cq_q [0:NS][0:2];
  logic [1:0]           cact_q [0:NS];

  // phase fold of the inputs into quadrant and residual
  logic [AB-1:0] ang [0:2];
  logic [AB-1:0] qsum [0:2];
  logic [1:0]    q_in [0:2];
  logic [AB-1:0] dres [0:2];
  logic [31:0]   ph   [0:2];
  always_comb begin
    ang[0] = angle_x_i;
    ang[1] = angle_y_i;
    ang[2] = angle_z_i;
    for (int a = 0; a < 3; a++) begin
      qsum[a] = ang[a] + AB'(1 << (AB - 3));
      q_in[a] = qsum[a][AB-1 -: 2];
      dres[a] = ang[a] - {q_in[a], {(AB-2){1'b0}}};
      ph[a]   = {dres[a], {(32-AB){1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cact_q[0] <= action_i;
      for (int a = 0; a < 3; a++) begin
        cx_q[0][a] <= erm_pkg::GAIN_Q40;
        cy_q[0][a] <= '0;
        cz_q[0][a] <= ZW'(signed'(ph[a]));
        cq_q[0][a] <= q_in[a];
      end
    end
  end

  // one cordic micro-rotation per stage, three angles side by side
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    always_ff @(posedge clk_i) begin
      if (en) begin
        cact_q[i+1] <= cact_q[i];
        for (int a = 0; a < 3; a++) begin
          cq_q[i+1][a] <= cq_q[i][a];
          if (!cz_q[i][a][ZW-1]) begin
            cx_q[i+1][a] <= cx_q[i][a] - (cy_q[i][a] >>> i);
            cy_q[i+1][a] <= cy_q[i][a] + (cx_q[i][a] >>> i);
            cz_q[i+1][a] <= cz_q[i][a] - erm_pkg::atan_turn(i);
          end else begin
            cx_q[i+1][a] <= cx_q[i][a] + (cy_q[i][a] >>> i);
            cy_q[i+1][a] <= cy_q[i][a] - (cx_q[i][a] >>> i);
            cz_q[i+1][a] <= cz_q[i][a] + erm_pkg::atan_turn(i);
          end
        end
      end
    end
  end

  // quadrant unfold and rounding to Q1.14
  logic signed [XW-1:0] cr [0:2];
  logic signed [XW-1:0] sr [0:2];
  logic signed [XW-1:0] cr_sh [0:2];
  logic signed [XW-1:0] sr_sh [0:2];
  erm_pkg::entry_t cos_q [0:2];
  erm_pkg::entry_t sin_q [0:2];
  logic [1:0] ract_q;
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      unique case (cq_q[NS][a])
        2'd0: begin cr[a] = cx_q[NS][a];  sr[a] = cy_q[NS][a];  end
        2'd1: begin cr[a] = -cy_q[NS][a]; sr[a] = cx_q[NS][a];  end
        2'd2: begin cr[a] = -cx_q[NS][a]; sr[a] = -cy_q[NS][a]; end
        default: begin cr[a] = cy_q[NS][a]; sr[a] = -cx_q[NS][a]; end
      endcase
      cr_sh[a] = (cr[a] + XW'(64'sd1 << (RSH - 1))) >>> RSH;
      sr_sh[a] = (sr[a] + XW'(64'sd1 << (RSH - 1))) >>> RSH;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ract_q <= cact_q[NS];
      for (int a = 0; a < 3; a++) begin
        cos_q[a] <= erm_pkg::sat_one(cr_sh[a][SW-1:0]);
        sin_q[a] <= erm_pkg::sat_one(sr_sh[a][SW-1:0]);
      end
    end
  end

  // elementary matrices
  erm_pkg::entry_t mrx [0:8];
  erm_pkg::entry_t mry [0:8];
  erm_pkg::entry_t mrz [0:8];
  erm_pkg::entry_t melem [0:8];
  always_comb begin
    for (int e = 0; e < 9; e++) begin
      mrx[e] = '0;
      mry[e] = '0;
      mrz[e] = '0;
    end
    mrx[0] = erm_pkg::ONE;  mrx[4] = cos_q[0]; mrx[5] = -sin_q[0];
    mrx[7] = sin_q[0];      mrx[8] = cos_q[0];
    mry[0] = cos_q[1];      mry[2] = sin_q[1]; mry[4] = erm_pkg::ONE;
    mry[6] = -sin_q[1];     mry[8] = cos_q[1];
    mrz[0] = cos_q[2];      mrz[1] = -sin_q[2]; mrz[3] = sin_q[2];
    mrz[4] = cos_q[2];      mrz[8] = erm_pkg::ONE;
    unique case (erm_pkg::action_e'(ract_q))
      erm_pkg::ACT_ROT_X: for (int e = 0; e < 9; e++) melem[e] = mrx[e];
      erm_pkg::ACT_ROT_Y: for (int e = 0; e < 9; e++) melem[e] = mry[e];
      default:            for (int e = 0; e < 9; e++) melem[e] = mrz[e];
    endcase
  end

  // first product stage: Ry * Rz partial products
  logic signed [PW-1:0] p1_q [0:8][0:2];
  erm_pkg::entry_t rx1_q [0:8];
  erm_pkg::entry_t el1_q [0:8];
  logic [1:0] act1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      act1_q <= ract_q;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          for (int k = 0; k < 3; k++)
            p1_q[i*3+j][k] <= PW'(mry[i*3+k]) * PW'(mrz[k*3+j]);
      for (int e = 0; e < 9; e++) begin
        rx1_q[e] <= mrx[e];
        el1_q[e] <= melem[e];
      end
    end
  end

  // first sum stage: round and clamp Ry*Rz
  logic signed [PW-1:0] s1 [0:8];
  erm_pkg::entry_t yz_q [0:8];
  erm_pkg::entry_t rx2_q [0:8];
  erm_pkg::entry_t el2_q [0:8];
  logic [1:0] act2_q;
  always_comb begin
    for (int e = 0; e < 9; e++)
      s1[e] = (p1_q[e][0] + p1_q[e][1] + p1_q[e][2] + PW'(1 << (FB - 1))) >>> FB;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      act2_q <= act1_q;
      for (int e = 0; e < 9; e++) begin
        yz_q[e]  <= erm_pkg::sat_one(s1[e][SW-1:0]);
        rx2_q[e] <= rx1_q[e];
        el2_q[e] <= el1_q[e];
      end
    end
  end

  // second product stage: Rx * (Ry*Rz)
  logic signed [PW-1:0] p2_q [0:8][0:2];
  erm_pkg::entry_t el3_q [0:8];
  logic [1:0] act3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      act3_q <= act2_q;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          for (int k = 0; k < 3; k++)
            p2_q[i*3+j][k] <= PW'(rx2_q[i*3+k]) * PW'(yz_q[k*3+j]);
      for (int e = 0; e < 9; e++) el3_q[e] <= el2_q[e];
    end
  end

  // final sum stage and result select
  logic signed [PW-1:0] s2 [0:8];
  erm_pkg::entry_t f_q [0:8];
  logic [1:0] fact_q;
  always_comb begin
    for (int e = 0; e < 9; e++)
      s2[e] = (p2_q[e][0] + p2_q[e][1] + p2_q[e][2] + PW'(1 << (FB - 1))) >>> FB;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      fact_q <= act3_q;
      for (int e = 0; e < 9; e++) begin
        if (erm_pkg::action_e'(act3_q) == erm_pkg::ACT_COMPOSITE) begin
          f_q[e] <= erm_pkg::sat_one(s2[e][SW-1:0]);
        end else begin
          f_q[e] <= el3_q[e];
        end
      end
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q  <= '0;
      rv_q  <= 1'b0;
      p1v_q <= 1'b0;
      a1v_q <= 1'b0;
      p2v_q <= 1'b0;
      fv_q  <= 1'b0;
    end else if (en) begin
      cv_q  <= {cv_q[NS-1:0], in_valid_i};
      rv_q  <= cv_q[NS];
      p1v_q <= rv_q;
      a1v_q <= p1v_q;
      p2v_q <= a1v_q;
      fv_q  <= p2v_q;
    end
  end

  // skid register holds a result the receiver did not take
  erm_pkg::entry_t skid_q [0:8];
  logic [1:0] skid_act_q;
  logic skid_v_d;
  always_comb begin
    if (skid_v_q) skid_v_d = !out_ready_i;
    else skid_v_d = fv_q && !out_ready_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else begin
      skid_v_q <= skid_v_d;
    end
  end
  always_ff @(posedge clk_i) begin
    if (!skid_v_q && fv_q && !out_ready_i) begin
      skid_act_q <= fact_q;
      for (int e = 0; e < 9; e++) skid_q[e] <= f_q[e];
    end
  end

  // output mux
  erm_pkg::entry_t om [0:8];
  logic [1:0] out_act;
  always_comb begin
    for (int e = 0; e < 9; e++) om[e] = skid_v_q ? skid_q[e] : f_q[e];
    out_act = skid_v_q ? skid_act_q : fact_q;
  end
  assign out_valid_o = skid_v_q || fv_q;
  assign row0_col0_o = om[0];
  assign row0_col1_o = om[1];
  assign row0_col2_o = om[2];
  assign row1_col0_o = om[3];
  assign row1_col1_o = om[4];
  assign row1_col2_o = om[5];
  assign row2_col0_o = om[6];
  assign row2_col1_o = om[7];
  assign row2_col2_o = om[8];

`ifndef SYNTHESIS
  // skid only fills from a stalled result
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(fv_q && !out_ready_i))
    else $error("skid filled without a stalled result");

  // pipeline holds while skid is full
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |=> $stable(fv_q))
    else $error("pipeline moved while skid full");

  // rotation about x keeps the x axis
  a_rot_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && erm_pkg::action_e'(out_act) == erm_pkg::ACT_ROT_X)
      |-> (om[0] == erm_pkg::ONE && om[1] == '0 && om[3] == '0))
    else $error("x rotation fixed entries wrong");

  // centre entry stays within one
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (om[4] <= erm_pkg::ONE && om[4] >= -erm_pkg::ONE))
    else $error("entry out of range");
`endif

endmodule
`default_nettype wire

### dv/tb_top.sv
// tb_top: self-checking testbench for euler_rotation_matrix_unit
// drives directed and random angle triples and actions, predicts each matrix and checks it
// depends on erm_pkg and euler_rotation_matrix_unit
`default_nettype none
module tb_top;
  import erm_pkg::*;

  typedef logic signed [15:0] mat9_t [9];

  typedef struct {
    mat9_t e;
  } matrix_t;

  // arctangent table, 2^32 per turn
  localparam longint ATAN_TURN [28] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81, 40, 20, 10, 5};
  localparam longint CORDIC_START = 64'sd667681663043;
  localparam longint UNIT = 64'sd16384;

  // clamp to [-1.0, 1.0] in Q1.14
  function automatic longint clamp_unit(input longint v);
    if (v > UNIT) return UNIT;
    if (v < -UNIT) return -UNIT;
    return v;
  endfunction

  // Q40 to Q14 with round half up
  function automatic longint q40_to_q14(input longint v);
    return clamp_unit((v + (64'sd1 <<< 25)) >>> 26);
  endfunction

  // quadrant fold then cordic rotation
  function automatic void calc_sincos(input logic [15:0] ang, output longint s,
                                      output longint c);
    logic [31:0] ph;
    logic [1:0] q;
    logic [31:0] d;
    longint z, x, y, xs, ys, cr, sr;
    ph = {ang, 16'h0};
    q = 2'((ph + 32'h2000_0000) >> 30);
    d = ph - ({30'd0, q} << 30);
    z = d[31] ? longint'(d) - 64'sd4294967296 : longint'(d);
    x = CORDIC_START;
    y = 0;
    for (int i = 0; i < 28; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ATAN_TURN[i];
      end else begin
        x += ys; y -= xs; z += ATAN_TURN[i];
      end
    end
    case (q)
      2'd0: begin cr = x; sr = y; end
      2'd1: begin cr = -y; sr = x; end
      2'd2: begin cr = -x; sr = -y; end
      default: begin cr = y; sr = -x; end
    endcase
    c = q40_to_q14(cr);
    s = q40_to_q14(sr);
  endfunction

  function automatic void axis_matrix(input action_e ax, input logic [15:0] ang,
                                      output longint m [9]);
    longint s, c;
    calc_sincos(ang, s, c);
    foreach (m[i]) m[i] = 0;
    case (ax)
      ACT_ROT_X: begin
        m[0] = UNIT; m[4] = c; m[5] = -s; m[7] = s; m[8] = c;
      end
      ACT_ROT_Y: begin
        m[0] = c; m[2] = s; m[4] = UNIT; m[6] = -s; m[8] = c;
      end
      default: begin
        m[0] = c; m[1] = -s; m[3] = s; m[4] = c; m[8] = UNIT;
      end
    endcase
  endfunction

  // product with one rounding per entry
  function automatic void fixed_matmul(input longint a [9], input longint b [9],
                                       output longint r [9]);
    longint acc;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += a[i*3+k] * b[k*3+j];
        r[i*3+j] = clamp_unit((acc + 64'sd8192) >>> 14);
      end
  endfunction

  function automatic matrix_t predict_rotation(input action_e act, input logic [15:0] ax,
                                               input logic [15:0] ay, input logic [15:0] az);
    longint rx [9], ry [9], rz [9], yz [9], m [9];
    matrix_t r;
    case (act)
      ACT_ROT_X: axis_matrix(ACT_ROT_X, ax, m);
      ACT_ROT_Y: axis_matrix(ACT_ROT_Y, ay, m);
      ACT_ROT_Z: axis_matrix(ACT_ROT_Z, az, m);
      default: begin
        axis_matrix(ACT_ROT_X, ax, rx);
        axis_matrix(ACT_ROT_Y, ay, ry);
        axis_matrix(ACT_ROT_Z, az, rz);
        fixed_matmul(ry, rz, yz);
        fixed_matmul(rx, yz, m);
      end
    endcase
    foreach (m[i]) r.e[i] = 16'(m[i]);
    return r;
  endfunction

  // scoreboard of pending matrices
  class matrix_scoreboard;
    matrix_t pending[$];
    int errors;
    int checked;
    int act_seen [4];

    function void note_input(action_e act, logic [15:0] ax, logic [15:0] ay,
                             logic [15:0] az);
      pending.push_back(predict_rotation(act, ax, ay, az));
      act_seen[act]++;
    endfunction

    function void check_matrix(mat9_t got);
      matrix_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result transfer", $time);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      foreach (got[i])
        if (got[i] !== want.e[i]) begin
          $display("%0t: entry %0d expected %0d actual %0d", $time, i, want.e[i], got[i]);
          errors++;
        end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] action = '0;
  logic [15:0] angle_x = '0, angle_y = '0, angle_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mat9_t res;
  logic long_hold = 1'b0;
  bit stim_done = 1'b0;
  matrix_scoreboard sb;

  always #2 clk = ~clk;

  euler_rotation_matrix_unit i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .action_i(action), .angle_x_i(angle_x), .angle_y_i(angle_y), .angle_z_i(angle_z),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .row0_col0_o(res[0]), .row0_col1_o(res[1]), .row0_col2_o(res[2]),
    .row1_col0_o(res[3]), .row1_col1_o(res[4]), .row1_col2_o(res[5]),
    .row2_col0_o(res[6]), .row2_col1_o(res[7]), .row2_col2_o(res[8])
  );

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(1, 3);
  endfunction

  // offer one item and hold it until the transfer
  task automatic send_item(input action_e act, input logic [15:0] ax,
                           input logic [15:0] ay, input logic [15:0] az,
                           input bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    angle_x <= ax;
    angle_y <= ay;
    angle_z <= az;
    do @(posedge clk); while (!in_ready);
    sb.note_input(act, ax, ay, az);
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 3)) << 14;
      1: return (16'($urandom_range(0, 7)) << 13) + 16'($urandom_range(0, 4)) - 16'd2;
      default: return 16'($urandom);
    endcase
  endfunction

  // directed corners then random items
  initial begin : stimulus
    logic [15:0] corners [12];
    bit burst;
    sb = new();
    corners = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h2000, 16'hE000,
                16'h1FFF, 16'h2001, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < 12; i++)
      send_item(action_e'(i % 4), corners[i], corners[(i + 3) % 12],
                corners[(i + 7) % 12], 1'b0);
    send_item(ACT_COMPOSITE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_item(ACT_COMPOSITE, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_item(ACT_ROT_X, 16'h1234, 16'hFFFF, 16'h0000, 1'b0);
    send_item(ACT_ROT_Y, 16'hFFFF, 16'h4321, 16'hFFFF, 1'b0);
    send_item(ACT_ROT_Z, 16'h0000, 16'hFFFF, 16'h9ABC, 1'b0);
    for (int n = 0; n < 1150; n++) begin
      burst = (n % 200) < 40;
      send_item(action_e'($urandom_range(0, 3)), rand_angle(), rand_angle(), rand_angle(),
                burst);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: random stalls plus one long hold-off
  initial begin : receiver
    int g;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (sb.checked >= 300 && !long_hold) begin
        long_hold <= 1'b1;
        out_ready <= 1'b0;
        repeat (150) @(posedge clk);
      end
      g = gap_len();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // sample result transfers
  always @(posedge clk)
    if (rst_n && out_valid && out_ready) sb.check_matrix(res);

  initial begin : finish_run
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d matrices: x %0d, y %0d, z %0d, composite %0d",
             sb.checked, sb.act_seen[0], sb.act_seen[1], sb.act_seen[2], sb.act_seen[3]);
    $display("including a long output hold-off that backed up the input");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire
